### sv/bvfm_pkg.sv
// Package with the shared types and constants of the bus voltage fault monitor.
`timescale 1ns / 1ps

package bvfm_pkg;

    // Fault slots, also the bit positions of the condition vectors.
    localparam int FLT_HV_OVER  = 0;
    localparam int FLT_HV_UNDER = 1;
    localparam int FLT_LV_OVER  = 2;
    localparam int FLT_LV_UNDER = 3;
    localparam int NUM_FAULTS   = 4;

    // Depth of both queues of the block.
    localparam int QUEUE_DEPTH = 2;

    // Accumulator width in bits; accumulators count ticks and saturate at all ones.
    localparam int ACC_W = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HV_OVER_SET   = 3'd0,
        CFG_HV_OVER_CLEAR = 3'd1,
        CFG_HV_UNDER_SET  = 3'd2,
        CFG_HV_UNDER_CLEAR = 3'd3,
        CFG_LV_OVER_SET   = 3'd4,
        CFG_LV_OVER_CLEAR = 3'd5,
        CFG_LV_UNDER_SET  = 3'd6,
        CFG_LV_UNDER_CLEAR = 3'd7
    } t_cfg_idx;

    // One input request.
    typedef struct packed {
        logic [11:0] hv_sample;
        logic        hv_sample_new;
        logic [15:0] lv_level;
        logic [15:0] elapsed_ticks;
    } t_in_req;

    // One result request.
    typedef struct packed {
        logic [15:0] hv_level;
        logic        hv_over_fault;
        logic        hv_under_fault;
        logic        lv_over_fault;
        logic        lv_under_fault;
        logic        any_fault;
    } t_out_req;

    // A classified request handed from the front part to the back part.
    typedef struct packed {
        logic [15:0]           hv_level;
        logic [NUM_FAULTS-1:0] set_cond;
        logic [NUM_FAULTS-1:0] clr_cond;
        logic [15:0]           ticks;
    } t_class;

endpackage

### sv/bvfm_queue.sv
// Small register-based FIFO queue used between the parts of the monitor.
`timescale 1ns / 1ps

module bvfm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = bvfm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue push without pop did not grow occupancy");
`endif

endmodule

### sv/bvfm_front.sv
// Front part: configuration registers, HV averaging and threshold classification.
`timescale 1ns / 1ps

module bvfm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bvfm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bvfm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_accept,
    input  bvfm_pkg::t_in_req                  i_in_req,
    output bvfm_pkg::t_class                   o_cls
);

    logic [15:0] r_hv_over_set, r_hv_over_clear, r_hv_under_set, r_hv_under_clear;
    logic [15:0] r_lv_over_set, r_lv_over_clear, r_lv_under_set, r_lv_under_clear;
    logic [15:0] r_hv_avg;
    logic [16:0] avg_sum;
    logic [15:0] hv_now;
    logic [15:0] lv_now;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv_over_set    <= 16'hFFFF;
            r_hv_over_clear  <= 16'hFFFF;
            r_hv_under_set   <= 16'h0000;
            r_hv_under_clear <= 16'h0000;
            r_lv_over_set    <= 16'hFFFF;
            r_lv_over_clear  <= 16'hFFFF;
            r_lv_under_set   <= 16'h0000;
            r_lv_under_clear <= 16'h0000;
        end else if (i_cfg_we) begin
            case (bvfm_pkg::t_cfg_idx'(i_cfg_idx))
                bvfm_pkg::CFG_HV_OVER_SET:    r_hv_over_set    <= i_cfg_data;
                bvfm_pkg::CFG_HV_OVER_CLEAR:  r_hv_over_clear  <= i_cfg_data;
                bvfm_pkg::CFG_HV_UNDER_SET:   r_hv_under_set   <= i_cfg_data;
                bvfm_pkg::CFG_HV_UNDER_CLEAR: r_hv_under_clear <= i_cfg_data;
                bvfm_pkg::CFG_LV_OVER_SET:    r_lv_over_set    <= i_cfg_data;
                bvfm_pkg::CFG_LV_OVER_CLEAR:  r_lv_over_clear  <= i_cfg_data;
                bvfm_pkg::CFG_LV_UNDER_SET:   r_lv_under_set   <= i_cfg_data;
                bvfm_pkg::CFG_LV_UNDER_CLEAR: r_lv_under_clear <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A new sample is scaled by eight and averaged with the stored level.
    assign avg_sum = {1'b0, r_hv_avg} + {2'b00, i_in_req.hv_sample, 3'b000};
    assign hv_now  = i_in_req.hv_sample_new ? avg_sum[16:1] : r_hv_avg;
    assign lv_now  = i_in_req.lv_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv_avg <= '0;
        end else if (i_accept) begin
            r_hv_avg <= hv_now;
        end
    end

    // Threshold classification on the updated HV average and the LV reading.
    always_comb begin
        o_cls.hv_level = hv_now;
        o_cls.ticks    = i_in_req.elapsed_ticks;
        o_cls.set_cond[bvfm_pkg::FLT_HV_OVER]  = hv_now > r_hv_over_set;
        o_cls.clr_cond[bvfm_pkg::FLT_HV_OVER]  = hv_now < r_hv_over_clear;
        o_cls.set_cond[bvfm_pkg::FLT_HV_UNDER] = hv_now < r_hv_under_set;
        o_cls.clr_cond[bvfm_pkg::FLT_HV_UNDER] = hv_now > r_hv_under_clear;
        o_cls.set_cond[bvfm_pkg::FLT_LV_OVER]  = lv_now > r_lv_over_set;
        o_cls.clr_cond[bvfm_pkg::FLT_LV_OVER]  = lv_now < r_lv_over_clear;
        o_cls.set_cond[bvfm_pkg::FLT_LV_UNDER] = lv_now < r_lv_under_set;
        o_cls.clr_cond[bvfm_pkg::FLT_LV_UNDER] = lv_now > r_lv_under_clear;
    end

endmodule

### sv/bvfm_back.sv
// Back part: time qualification of the four latched faults and result assembly.
`timescale 1ns / 1ps

module bvfm_back #(
    parameter int HV_OVER_TICKS  = 100000,
    parameter int HV_UNDER_TICKS = 300000,
    parameter int LV_SET_TICKS   = 20000,
    parameter int LV_CLEAR_TICKS = 100000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  bvfm_pkg::t_class   i_cls,
    output bvfm_pkg::t_out_req o_res
);

    localparam int NF = bvfm_pkg::NUM_FAULTS;
    localparam int AW = bvfm_pkg::ACC_W;

    localparam logic [AW-1:0] SET_T [NF] = '{
        AW'(HV_OVER_TICKS), AW'(HV_UNDER_TICKS), AW'(LV_SET_TICKS), AW'(LV_SET_TICKS)
    };
    localparam logic [AW-1:0] CLR_T [NF] = '{
        AW'(HV_OVER_TICKS), AW'(HV_UNDER_TICKS), AW'(LV_CLEAR_TICKS), AW'(LV_CLEAR_TICKS)
    };

    logic [NF-1:0] r_flag, n_flag;
    logic [AW-1:0] r_acc_set [NF];
    logic [AW-1:0] n_acc_set [NF];
    logic [AW-1:0] r_acc_clr [NF];
    logic [AW-1:0] n_acc_clr [NF];

    genvar k;
    generate
        for (k = 0; k < NF; k++) begin : g_fault
            logic [AW:0]   set_sum;
            logic [AW:0]   clr_sum;
            logic [AW-1:0] set_sat;
            logic [AW-1:0] clr_sat;

            // Saturating accumulation of elapsed ticks.
            assign set_sum = {1'b0, r_acc_set[k]} + {{(AW - 15){1'b0}}, i_cls.ticks};
            assign clr_sum = {1'b0, r_acc_clr[k]} + {{(AW - 15){1'b0}}, i_cls.ticks};
            assign set_sat = set_sum[AW] ? {AW{1'b1}} : set_sum[AW-1:0];
            assign clr_sat = clr_sum[AW] ? {AW{1'b1}} : clr_sum[AW-1:0];

            // Set qualification while clear, recovery qualification while latched.
            always_comb begin
                n_flag[k]    = r_flag[k];
                n_acc_set[k] = r_acc_set[k];
                n_acc_clr[k] = r_acc_clr[k];
                if (!r_flag[k]) begin
                    n_acc_clr[k] = '0;
                    if (i_cls.set_cond[k]) begin
                        if (r_acc_set[k] > SET_T[k]) begin
                            n_flag[k]    = 1'b1;
                            n_acc_set[k] = '0;
                        end else begin
                            n_acc_set[k] = set_sat;
                        end
                    end else begin
                        n_acc_set[k] = '0;
                    end
                end else begin
                    n_acc_set[k] = '0;
                    if (i_cls.clr_cond[k]) begin
                        if (r_acc_clr[k] > CLR_T[k]) begin
                            n_flag[k]    = 1'b0;
                            n_acc_clr[k] = '0;
                        end else begin
                            n_acc_clr[k] = clr_sat;
                        end
                    end else begin
                        n_acc_clr[k] = '0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_flag[k]    <= 1'b0;
                    r_acc_set[k] <= '0;
                    r_acc_clr[k] <= '0;
                end else if (i_take) begin
                    r_flag[k]    <= n_flag[k];
                    r_acc_set[k] <= n_acc_set[k];
                    r_acc_clr[k] <= n_acc_clr[k];
                end
            end
        end
    endgenerate

    // The result carries the fault state after this request's update.
    always_comb begin
        o_res.hv_level       = i_cls.hv_level;
        o_res.hv_over_fault  = n_flag[bvfm_pkg::FLT_HV_OVER];
        o_res.hv_under_fault = n_flag[bvfm_pkg::FLT_HV_UNDER];
        o_res.lv_over_fault  = n_flag[bvfm_pkg::FLT_LV_OVER];
        o_res.lv_under_fault = n_flag[bvfm_pkg::FLT_LV_UNDER];
        o_res.any_fault      = |n_flag;
    end

`ifndef SYNTH
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_flag))
        else $error("fault flags changed without a request");

    generate
        for (k = 0; k < NF; k++) begin : g_chk
            a_idle_acc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_flag[k] ? (r_acc_set[k] == '0) : (r_acc_clr[k] == '0)))
                else $error("inactive accumulator of a fault is not zero");
        end
    endgenerate
`endif

endmodule

### sv/bus_voltage_fault_monitor_core.sv
// Top level of the bus voltage fault monitor: front part, queues and back part.
//
// Usage: input requests (HV sample, new-sample flag, LV level, elapsed ticks)
// are written like into a FIFO: a request is taken at a clock edge with push
// high and full low. Results are read like from a FIFO: while empty is low the
// oldest result is on o_out_req, and it is taken at an edge with pop high.
// Each request yields exactly one result: the averaged HV level and the four
// latched fault flags plus their OR, after that request's update.
// An accepted request is classified into the inner queue, and its result is
// written to the output queue; one request per cycle is sustained while the
// reader pops, bounded by the back part's saturating add and compare per fault.
// The front part classifies requests into a two-entry queue; the back part
// writes results into a two-entry output queue, so a stalled reader fills
// that queue, then the inner queue, and only then raises full.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data while no request is in flight. Synchronous reset empties both
// queues, clears the average, the accumulators and the faults, and reloads
// the thresholds with their default values.
`timescale 1ns / 1ps

module bus_voltage_fault_monitor_core #(
    parameter int HV_OVER_TICKS  = 100000,
    parameter int HV_UNDER_TICKS = 300000,
    parameter int LV_SET_TICKS   = 20000,
    parameter int LV_CLEAR_TICKS = 100000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  bvfm_pkg::t_in_req               i_in_req,
    input  logic                            pop,
    output logic                            empty,
    output bvfm_pkg::t_out_req              o_out_req,
    input  logic                            i_cfg_we,
    input  logic [bvfm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bvfm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CLS_W = $bits(bvfm_pkg::t_class);
    localparam int RES_W = $bits(bvfm_pkg::t_out_req);

    logic               accept;
    bvfm_pkg::t_class   front_cls;
    logic [CLS_W-1:0]   mid_data;
    logic               mid_empty;
    logic               res_full;
    logic               take;
    bvfm_pkg::t_out_req back_res;
    logic [RES_W-1:0]   out_data;

    assign accept = push && !full;

    // Front part: classify each accepted request.
    bvfm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_in_req   (i_in_req),
        .o_cls      (front_cls)
    );

    // Queue between the front and back parts.
    bvfm_queue #(
        .WIDTH (CLS_W)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    // The back part takes a request whenever the output queue has room.
    assign take = !mid_empty && !res_full;

    bvfm_back #(
        .HV_OVER_TICKS  (HV_OVER_TICKS),
        .HV_UNDER_TICKS (HV_UNDER_TICKS),
        .LV_SET_TICKS   (LV_SET_TICKS),
        .LV_CLEAR_TICKS (LV_CLEAR_TICKS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_cls   (bvfm_pkg::t_class'(mid_data)),
        .o_res   (back_res)
    );

    // Output queue holding finished results for the reader.
    bvfm_queue #(
        .WIDTH (RES_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_out_req = bvfm_pkg::t_out_req'(out_data);

endmodule

### verif/bus_voltage_fault_monitor_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bus voltage fault monitor core.

module bus_voltage_fault_monitor_core_test;

    localparam int HV_OVER_TICKS  = 100000;
    localparam int HV_UNDER_TICKS = 300000;
    localparam int LV_SET_TICKS   = 20000;
    localparam int LV_CLEAR_TICKS = 100000;

    localparam int CLK_HALF_NS  = 5;
    localparam int LIMIT_NS     = 2000000;
    localparam int IDLE_PCT     = 21;
    localparam int SHOWN_ERRORS = 10;

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            push     = 1'b0;
    logic                            full;
    bvfm_pkg::t_in_req               in_req   = '0;
    logic                            pop      = 1'b0;
    logic                            empty;
    bvfm_pkg::t_out_req              out_req;
    logic                            cfg_we   = 1'b0;
    logic [bvfm_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [bvfm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Knobs shared between the stimulus and the result reader.
    bit sender_gaps  = 1'b1;
    bit reader_gaps  = 1'b1;
    int stall_cycles = 0;

    // Tracks thresholds, HV average, fault latches and timers; holds the
    // status words the block owes for requests it has taken.
    class fault_tracker;
        logic [15:0]                     thresh [8];
        logic [15:0]                     hv_avg;
        logic [bvfm_pkg::NUM_FAULTS-1:0] latched;
        logic [bvfm_pkg::ACC_W-1:0]      set_acc [bvfm_pkg::NUM_FAULTS];
        logic [bvfm_pkg::ACC_W-1:0]      rec_acc [bvfm_pkg::NUM_FAULTS];
        int unsigned                     set_limit [bvfm_pkg::NUM_FAULTS];
        int unsigned                     rec_limit [bvfm_pkg::NUM_FAULTS];
        bvfm_pkg::t_out_req              pending_status [$];
        int                              mismatches;

        function new();
            // Over thresholds reset to full scale, under thresholds to zero.
            thresh = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                       16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
            hv_avg = '0;
            latched = '0;
            for (int k = 0; k < bvfm_pkg::NUM_FAULTS; k++) begin
                set_acc[k] = '0;
                rec_acc[k] = '0;
            end
            set_limit[bvfm_pkg::FLT_HV_OVER]  = HV_OVER_TICKS;
            rec_limit[bvfm_pkg::FLT_HV_OVER]  = HV_OVER_TICKS;
            set_limit[bvfm_pkg::FLT_HV_UNDER] = HV_UNDER_TICKS;
            rec_limit[bvfm_pkg::FLT_HV_UNDER] = HV_UNDER_TICKS;
            set_limit[bvfm_pkg::FLT_LV_OVER]  = LV_SET_TICKS;
            rec_limit[bvfm_pkg::FLT_LV_OVER]  = LV_CLEAR_TICKS;
            set_limit[bvfm_pkg::FLT_LV_UNDER] = LV_SET_TICKS;
            rec_limit[bvfm_pkg::FLT_LV_UNDER] = LV_CLEAR_TICKS;
            mismatches = 0;
        endfunction

        function void write_threshold(bvfm_pkg::t_cfg_idx idx, logic [15:0] value);
            thresh[idx] = value;
        endfunction

        // Timers stick at all ones instead of wrapping.
        function logic [bvfm_pkg::ACC_W-1:0] sat_add(logic [bvfm_pkg::ACC_W-1:0] acc,
                                                     logic [15:0] ticks);
            logic [bvfm_pkg::ACC_W:0] sum;
            sum = {1'b0, acc} + ticks;
            return sum[bvfm_pkg::ACC_W] ? '1 : sum[bvfm_pkg::ACC_W-1:0];
        endfunction

        // One fault: a condition must hold past its time to flip the latch,
        // and any break in the condition restarts its timer.
        function void qualify(int k, bit set_c, bit rec_c, logic [15:0] ticks);
            if (!latched[k]) begin
                rec_acc[k] = '0;
                if (set_c) begin
                    if (set_acc[k] > set_limit[k]) begin
                        latched[k] = 1'b1;
                        set_acc[k] = '0;
                    end else begin
                        set_acc[k] = sat_add(set_acc[k], ticks);
                    end
                end else begin
                    set_acc[k] = '0;
                end
            end else begin
                set_acc[k] = '0;
                if (rec_c) begin
                    if (rec_acc[k] > rec_limit[k]) begin
                        latched[k] = 1'b0;
                        rec_acc[k] = '0;
                    end else begin
                        rec_acc[k] = sat_add(rec_acc[k], ticks);
                    end
                end else begin
                    rec_acc[k] = '0;
                end
            end
        endfunction

        // Works out the status word for one accepted request.
        function void accept_sample(bvfm_pkg::t_in_req req);
            bvfm_pkg::t_out_req st;
            int unsigned        sum;
            logic [15:0]        lv;
            if (req.hv_sample_new) begin
                sum = int'(hv_avg) + 8 * int'(req.hv_sample);
                hv_avg = 16'(sum >> 1);
            end
            lv = req.lv_level;
            qualify(bvfm_pkg::FLT_HV_OVER, hv_avg > thresh[bvfm_pkg::CFG_HV_OVER_SET],
                    hv_avg < thresh[bvfm_pkg::CFG_HV_OVER_CLEAR], req.elapsed_ticks);
            qualify(bvfm_pkg::FLT_HV_UNDER, hv_avg < thresh[bvfm_pkg::CFG_HV_UNDER_SET],
                    hv_avg > thresh[bvfm_pkg::CFG_HV_UNDER_CLEAR], req.elapsed_ticks);
            qualify(bvfm_pkg::FLT_LV_OVER, lv > thresh[bvfm_pkg::CFG_LV_OVER_SET],
                    lv < thresh[bvfm_pkg::CFG_LV_OVER_CLEAR], req.elapsed_ticks);
            qualify(bvfm_pkg::FLT_LV_UNDER, lv < thresh[bvfm_pkg::CFG_LV_UNDER_SET],
                    lv > thresh[bvfm_pkg::CFG_LV_UNDER_CLEAR], req.elapsed_ticks);
            st.hv_level       = hv_avg;
            st.hv_over_fault  = latched[bvfm_pkg::FLT_HV_OVER];
            st.hv_under_fault = latched[bvfm_pkg::FLT_HV_UNDER];
            st.lv_over_fault  = latched[bvfm_pkg::FLT_LV_OVER];
            st.lv_under_fault = latched[bvfm_pkg::FLT_LV_UNDER];
            st.any_fault      = |latched;
            pending_status.push_back(st);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
        endfunction

        // Compares a popped status word with the oldest one owed.
        function void compare_status(bvfm_pkg::t_out_req got);
            bvfm_pkg::t_out_req want;
            if (pending_status.size() == 0) begin
                flag($sformatf("status %h popped with no request outstanding", got));
                return;
            end
            want = pending_status.pop_front();
            if (got.hv_level !== want.hv_level)
                flag($sformatf("hv_level expected %h got %h", want.hv_level, got.hv_level));
            if (got.hv_over_fault !== want.hv_over_fault)
                flag($sformatf("hv_over_fault expected %b got %b",
                               want.hv_over_fault, got.hv_over_fault));
            if (got.hv_under_fault !== want.hv_under_fault)
                flag($sformatf("hv_under_fault expected %b got %b",
                               want.hv_under_fault, got.hv_under_fault));
            if (got.lv_over_fault !== want.lv_over_fault)
                flag($sformatf("lv_over_fault expected %b got %b",
                               want.lv_over_fault, got.lv_over_fault));
            if (got.lv_under_fault !== want.lv_under_fault)
                flag($sformatf("lv_under_fault expected %b got %b",
                               want.lv_under_fault, got.lv_under_fault));
            if (got.any_fault !== want.any_fault)
                flag($sformatf("any_fault expected %b got %b", want.any_fault, got.any_fault));
        endfunction
    endclass

    fault_tracker tracker;

    bus_voltage_fault_monitor_core #(
        .HV_OVER_TICKS (HV_OVER_TICKS),
        .HV_UNDER_TICKS(HV_UNDER_TICKS),
        .LV_SET_TICKS  (LV_SET_TICKS),
        .LV_CLEAR_TICKS(LV_CLEAR_TICKS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_req  (in_req),
        .pop       (pop),
        .empty     (empty),
        .o_out_req (out_req),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // Clock generation.
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Result reader: random gaps, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            stall_cycles--;
            pop = 1'b0;
        end else begin
            pop = !reader_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every popped status word is checked at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            tracker.compare_status(out_req);
        end
    end

    function automatic bvfm_pkg::t_in_req make_req(logic [11:0] sample, logic fresh,
                                                   logic [15:0] lv, logic [15:0] ticks);
        bvfm_pkg::t_in_req req;
        req.hv_sample     = sample;
        req.hv_sample_new = fresh;
        req.lv_level      = lv;
        req.elapsed_ticks = ticks;
        return req;
    endfunction

    // A value near a centre, clipped to the field range.
    function automatic int jitter(int centre, int spread, int top);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v;
    endfunction

    // Offers one request and returns at the falling edge after it is taken.
    task automatic offer(input bvfm_pkg::t_in_req req);
        while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        in_req = req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tracker.accept_sample(req);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every owed status word has been popped.
    task automatic drain_results();
        push = 1'b0;
        while (tracker.pending_status.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input bvfm_pkg::t_cfg_idx idx, input logic [15:0] value);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(posedge i_clk);
        tracker.write_threshold(idx, value);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_thresholds(input int hos, input int hoc, input int hus, input int huc,
                                   input int los, input int loc, input int lus, input int luc);
        drain_results();
        write_reg(bvfm_pkg::CFG_HV_OVER_SET, 16'(hos));
        write_reg(bvfm_pkg::CFG_HV_OVER_CLEAR, 16'(hoc));
        write_reg(bvfm_pkg::CFG_HV_UNDER_SET, 16'(hus));
        write_reg(bvfm_pkg::CFG_HV_UNDER_CLEAR, 16'(huc));
        write_reg(bvfm_pkg::CFG_LV_OVER_SET, 16'(los));
        write_reg(bvfm_pkg::CFG_LV_OVER_CLEAR, 16'(loc));
        write_reg(bvfm_pkg::CFG_LV_UNDER_SET, 16'(lus));
        write_reg(bvfm_pkg::CFG_LV_UNDER_CLEAR, 16'(luc));
    endtask

    // Random stimulus: mostly stretches of steady bus levels with long tick
    // counts so faults latch and recover, mixed with fully random requests.
    task automatic run_phase(input int count, input bit squeeze);
        int                sent;
        int                seg_len;
        int                hv_centre;
        int                lv_centre;
        bvfm_pkg::t_in_req req;
        sent = 0;
        if (squeeze) begin
            // Reader holds off while requests keep coming, so the block fills.
            sender_gaps = 1'b0;
            @(posedge i_clk);
            stall_cycles = 90;
            @(negedge i_clk);
        end
        while (sent < count) begin
            seg_len = $urandom_range(12, 2);
            hv_centre = $urandom_range(4095);
            lv_centre = $urandom_range(65535);
            for (int n = 0; n < seg_len && sent < count; n++) begin
                if ($urandom_range(99) < 15) begin
                    req.hv_sample     = 12'($urandom_range(4095));
                    req.hv_sample_new = 1'($urandom_range(1));
                    req.lv_level      = 16'($urandom_range(65535));
                    req.elapsed_ticks = 16'($urandom_range(65535));
                end else begin
                    req.hv_sample     = 12'(jitter(hv_centre, 48, 4095));
                    req.hv_sample_new = ($urandom_range(7) != 0);
                    req.lv_level      = 16'(jitter(lv_centre, 800, 65535));
                    req.elapsed_ticks = 16'($urandom_range(65535, 15000));
                end
                offer(req);
                sent++;
                if (squeeze && sent == 40) sender_gaps = 1'b1;
            end
        end
    endtask

    task automatic load_random_thresholds();
        load_thresholds($urandom_range(32767), $urandom_range(32767),
                        $urandom_range(32767), $urandom_range(32767),
                        $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535));
    endtask

    // Main sequence.
    initial begin
        tracker = new();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Thresholds at their reset values: nothing can start a fault.
        offer(make_req(12'hFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        offer(make_req(12'h000, 1'b1, 16'h0000, 16'hFFFF));
        offer(make_req(12'hFFF, 1'b0, 16'h0000, 16'h0000));

        load_thresholds(24000, 20000, 8000, 12000, 50000, 45000, 15000, 20000);
        // High bus held past the overvoltage time, LV high as well.
        repeat (4) offer(make_req(12'hFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        // No new sample: the average is held and still drives the checks.
        offer(make_req(12'h000, 1'b0, 16'hFFFF, 16'h0000));
        // Bus collapses: overvoltage recovery and undervoltage timing start.
        repeat (3) offer(make_req(12'h000, 1'b1, 16'd30000, 16'hFFFF));
        // One high sample breaks the undervoltage condition and restarts its timer.
        offer(make_req(12'hFFF, 1'b1, 16'h0000, 16'hFFFF));
        repeat (7) offer(make_req(12'h000, 1'b1, 16'h0000, 16'hFFFF));
        // Both buses come back above their undervoltage clear levels.
        repeat (8) offer(make_req(12'd2000, 1'b1, 16'd30000, 16'hFFFF));

        run_phase(100, 1'b0);

        // All thresholds at zero.
        load_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
        run_phase(110, 1'b0);

        // All thresholds at full scale, with no gaps on either side.
        load_thresholds(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
        sender_gaps = 1'b0;
        reader_gaps = 1'b0;
        run_phase(110, 1'b0);
        sender_gaps = 1'b1;
        reader_gaps = 1'b1;

        // Back to the reset values.
        load_thresholds(65535, 65535, 0, 0, 65535, 65535, 0, 0);
        run_phase(90, 1'b0);

        load_random_thresholds();
        run_phase(110, 1'b0);

        load_thresholds(24000, 20000, 8000, 12000, 50000, 45000, 15000, 20000);
        run_phase(120, 1'b1);

        load_random_thresholds();
        run_phase(110, 1'b0);

        drain_results();
        repeat (8) @(negedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("bus_voltage_fault_monitor_core_test OK");
        end else begin
            $display("bus_voltage_fault_monitor_core_test NOT OK");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #LIMIT_NS;
        $display("bus_voltage_fault_monitor_core_test NOT OK");
        $finish;
    end

endmodule

### filelist.f
sv/bvfm_pkg.sv
sv/bvfm_queue.sv
sv/bvfm_front.sv
sv/bvfm_back.sv
sv/bus_voltage_fault_monitor_core.sv
verif/bus_voltage_fault_monitor_core_test.sv
